/* src/overwrite_ring_offset_lookup_core_defines.svh */
// Assertion macros shared by the ring lookup modules.
`ifndef OVERWRITE_RING_OFFSET_LOOKUP_CORE_DEFINES_SVH
`define OVERWRITE_RING_OFFSET_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ORLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ring lookup check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ORLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ring lookup check failed");

`endif

/* src/orlc_pkg.sv */
`timescale 1ns / 1ps

package orlc_pkg;

    // Default geometry of the ring.
    localparam int DEFAULT_DEPTH       = 16;
    localparam int DEFAULT_SIZE_BITS   = 16;
    localparam int DEFAULT_HANDLE_BITS = 32;

    // Fixed port widths.
    localparam int SIZE_PORT_W   = 16;
    localparam int HANDLE_PORT_W = 32;
    localparam int POS_W         = 20;
    localparam int OFFSET_W      = 16;
    localparam int STATUS_W      = 2;

    // Action codes.
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_FIND = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_STORED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_WALK
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic add_en;
        logic find_load;
        logic walk_en;
        logic check;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic hit;
        logic last;
    } sts_t;

endpackage

/* src/orlc_ctrl.sv */
`timescale 1ns / 1ps
`include "overwrite_ring_offset_lookup_core_defines.svh"

module orlc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          action,
    input  orlc_pkg::sts_t sts,
    output logic          busy,
    output orlc_pkg::ctl_t ctl
);
    import orlc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (action == ACT_FIND) && !sts.empty)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (sts.hit || sts.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.add_en    = accept && (action == ACT_ADD);
                ctl.find_load = accept && (action == ACT_FIND);
            end
            S_FETCH:
            begin
                ctl.walk_en = 1'b1;
            end
            S_WALK:
            begin
                ctl.walk_en = 1'b1;
                ctl.check   = 1'b1;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    // A fetch cycle is always followed by the compare walk.
    `ORLC_ASSERT_NEXT(a_fetch_to_walk, clk, rst_n, state_reg == S_FETCH, state_reg == S_WALK)
    // A find on a non-empty ring starts the walk.
    `ORLC_ASSERT_NEXT(a_find_starts, clk, rst_n, ctl.find_load && !sts.empty, state_reg == S_FETCH)

endmodule

/* src/orlc_dpath.sv */
`timescale 1ns / 1ps
`include "overwrite_ring_offset_lookup_core_defines.svh"

module orlc_dpath #(
    parameter int DEPTH       = orlc_pkg::DEFAULT_DEPTH,
    parameter int SIZE_BITS   = orlc_pkg::DEFAULT_SIZE_BITS,
    parameter int HANDLE_BITS = orlc_pkg::DEFAULT_HANDLE_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  orlc_pkg::ctl_t                        ctl,
    input  logic [orlc_pkg::SIZE_PORT_W-1:0]      entry_size,
    input  logic [orlc_pkg::HANDLE_PORT_W-1:0]    entry_handle,
    input  logic [orlc_pkg::POS_W-1:0]            byte_pos,
    output orlc_pkg::sts_t                        sts,
    output logic                                  done,
    output logic [orlc_pkg::STATUS_W-1:0]         status,
    output logic [orlc_pkg::HANDLE_PORT_W-1:0]    found_handle,
    output logic [orlc_pkg::SIZE_PORT_W-1:0]      found_size,
    output logic [orlc_pkg::OFFSET_W-1:0]         byte_offset
);
    import orlc_pkg::*;

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int BASE_W = SIZE_BITS + CNT_W;
    localparam int SUM_W  = ((BASE_W > POS_W) ? BASE_W : POS_W) + 1;
    localparam int ENT_W  = SIZE_BITS + HANDLE_BITS;

    // Entry memory: size in the upper field, handle in the lower.
    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    logic [IDX_W-1:0]  wr_idx_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              full_reg;
    logic [IDX_W-1:0]  wr_idx_next;
    logic [IDX_W-1:0]  rd_idx_next;
    logic              full_next;

    logic [IDX_W-1:0]  ptr_reg;
    logic [IDX_W-1:0]  ptr_next;
    logic [BASE_W-1:0] base_reg;
    logic [BASE_W-1:0] base_next;
    logic [CNT_W-1:0]  left_reg;
    logic [CNT_W-1:0]  left_next;
    logic [POS_W-1:0]  pos_reg;

    logic                 done_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [HANDLE_PORT_W-1:0] handle_reg;
    logic [SIZE_PORT_W-1:0]   size_reg;
    logic [OFFSET_W-1:0]      offset_reg;

    logic [SIZE_BITS-1:0]   add_size;
    logic [HANDLE_BITS-1:0] add_handle;
    logic                   add_store;
    logic [IDX_W-1:0]       wr_adv;
    logic [CNT_W-1:0]       count;
    logic [SIZE_BITS-1:0]   rd_size;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic [SUM_W-1:0]       sum;
    logic [SUM_W-1:0]       pos_ext;
    logic [SUM_W-1:0]       offset_full;
    logic                   finish;

    // Input fields resized to the stored widths.
    assign add_size   = SIZE_BITS'(entry_size);
    assign add_handle = HANDLE_BITS'(entry_handle);
    assign add_store  = ctl.add_en && (add_size != '0);

    // Write index advance with wrap, and the number of stored entries.
    assign wr_adv = (wr_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(wr_idx_reg + 1'b1);

    always_comb
    begin
        if (full_reg)
        begin
            count = CNT_W'(DEPTH);
        end
        else if (wr_idx_reg >= rd_idx_reg)
        begin
            count = CNT_W'(IDX_W'(wr_idx_reg - rd_idx_reg));
        end
        else
        begin
            count = CNT_W'(CNT_W'(DEPTH) + CNT_W'(wr_idx_reg) - CNT_W'(rd_idx_reg));
        end
    end

    // Ring index update on a stored add.
    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        full_next   = full_reg;
        if (add_store)
        begin
            wr_idx_next = wr_adv;
            if (full_reg)
            begin
                rd_idx_next = wr_adv;
            end
            else if (wr_adv == rd_idx_reg)
            begin
                full_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            full_reg   <= 1'b0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            full_reg   <= full_next;
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (add_store)
        begin
            mem[wr_idx_reg] <= {add_size, add_handle};
        end
        rd_data_reg <= mem[ptr_reg];
    end

    // Compare of the entry just read against the running base.
    assign rd_size     = rd_data_reg[HANDLE_BITS +: SIZE_BITS];
    assign rd_handle   = rd_data_reg[HANDLE_BITS-1:0];
    assign sum         = SUM_W'(base_reg) + SUM_W'(rd_size);
    assign pos_ext     = SUM_W'(pos_reg);
    assign offset_full = pos_ext - SUM_W'(base_reg);

    assign sts.empty = !full_reg && (wr_idx_reg == rd_idx_reg);
    assign sts.hit   = pos_ext < sum;
    assign sts.last  = (left_reg == CNT_W'(1));
    assign finish    = ctl.check && (sts.hit || sts.last);

    // Walk pointer, running base and remaining count.
    always_comb
    begin
        ptr_next  = ptr_reg;
        base_next = base_reg;
        left_next = left_reg;
        if (ctl.find_load)
        begin
            ptr_next  = rd_idx_reg;
            base_next = '0;
            left_next = count;
        end
        else
        begin
            if (ctl.walk_en)
            begin
                ptr_next = (ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(ptr_reg + 1'b1);
            end
            if (ctl.check && !sts.hit)
            begin
                base_next = BASE_W'(sum);
                left_next = CNT_W'(left_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        base_reg <= base_next;
        left_reg <= left_next;
        if (ctl.find_load)
        begin
            pos_reg <= byte_pos;
        end
    end

    // Result beat: one cycle strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.add_en || (ctl.find_load && sts.empty) || finish;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (ctl.add_en)
        begin
            status_reg <= add_store ? ST_STORED : ST_IGNORED;
            handle_reg <= '0;
            size_reg   <= '0;
            offset_reg <= '0;
        end
        else if (finish && sts.hit)
        begin
            status_reg <= ST_FOUND;
            handle_reg <= HANDLE_PORT_W'(rd_handle);
            size_reg   <= SIZE_PORT_W'(rd_size);
            offset_reg <= OFFSET_W'(offset_full);
        end
        else if (finish || ctl.find_load)
        begin
            status_reg <= ST_NOT_FOUND;
            handle_reg <= '0;
            size_reg   <= '0;
            offset_reg <= '0;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign found_handle = handle_reg;
    assign found_size   = size_reg;
    assign byte_offset  = offset_reg;

    // A full ring always has its indexes aligned.
    `ORLC_ASSERT_NOW(a_full_aligned, clk, rst_n, full_reg, wr_idx_reg == rd_idx_reg)
    // A compare never runs with no entries left to walk.
    `ORLC_ASSERT_NOW(a_walk_bounded, clk, rst_n, ctl.check, left_reg != '0)

endmodule

/* src/overwrite_ring_offset_lookup_core.sv */
`timescale 1ns / 1ps

// Ring of DEPTH entries (handle and byte size) that overwrites its oldest
// entry when full, with lookup of the entry holding a byte position of the
// concatenated data. An item is taken when start is high and busy is low.
// Each item yields exactly one result beat, shown for a single cycle with
// done high; the receiver cannot stall, so it must take every beat when it
// appears. An add's result appears in the next cycle. A find on an empty
// ring also answers in the next cycle; otherwise it goes through the fetch
// state and then the walk state, which compares the entries up to and
// including the hit, or all stored entries on a miss. The walk reads one
// entry per cycle through the single registered read port of the entry
// memory. Entries never written read as unknown, but a find only visits
// stored entries.
module overwrite_ring_offset_lookup_core #(
    parameter int DEPTH       = orlc_pkg::DEFAULT_DEPTH,
    parameter int SIZE_BITS   = orlc_pkg::DEFAULT_SIZE_BITS,
    parameter int HANDLE_BITS = orlc_pkg::DEFAULT_HANDLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               action,
    input  logic [orlc_pkg::SIZE_PORT_W-1:0]   entry_size,
    input  logic [orlc_pkg::HANDLE_PORT_W-1:0] entry_handle,
    input  logic [orlc_pkg::POS_W-1:0]         byte_pos,
    output logic                               done,
    output logic [orlc_pkg::STATUS_W-1:0]      status,
    output logic [orlc_pkg::HANDLE_PORT_W-1:0] found_handle,
    output logic [orlc_pkg::SIZE_PORT_W-1:0]   found_size,
    output logic [orlc_pkg::OFFSET_W-1:0]      byte_offset
);
    import orlc_pkg::*;

    ctl_t ctl;
    sts_t sts;

    // Sequencer.
    orlc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .busy   (busy),
        .ctl    (ctl)
    );

    // Ring storage, walk and result registers.
    orlc_dpath #(
        .DEPTH       (DEPTH),
        .SIZE_BITS   (SIZE_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .entry_size   (entry_size),
        .entry_handle (entry_handle),
        .byte_pos     (byte_pos),
        .sts          (sts),
        .done         (done),
        .status       (status),
        .found_handle (found_handle),
        .found_size   (found_size),
        .byte_offset  (byte_offset)
    );

endmodule
